@@ rtl/qov_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qov_pkg
// Shared widths, types and term tables for the quadric optimal vertex solver.
// ----------------------------------------------------------------------------
package qov_pkg;

    // Coefficient and intermediate widths
    localparam int COEF_W = 32;
    localparam int PROD_W = 2 * COEF_W;
    localparam int COF_W  = 2 * COEF_W + 1;
    localparam int PART_W = COF_W;
    localparam int HI_W   = COF_W - COEF_W;
    localparam int DW     = 3 * COEF_W + 4;

    // Divider geometry: 33 quotient bits cover the signed 32-bit range plus overflow
    localparam int FRAC    = 16;
    localparam int QB      = 33;
    localparam int NW      = DW + FRAC;
    localparam int RW      = DW + QB;
    localparam int DIV_LAT = QB + 3;

    // Pipeline depth: six front stages, divider, output register
    localparam int FRONT_LAT = 6;
    localparam int LAT       = FRONT_LAT + DIV_LAT + 1;

    // Input coefficient slots
    localparam int I_XX = 0;
    localparam int I_XY = 1;
    localparam int I_XZ = 2;
    localparam int I_XW = 3;
    localparam int I_YY = 4;
    localparam int I_YZ = 5;
    localparam int I_YW = 6;
    localparam int I_ZZ = 7;
    localparam int I_ZW = 8;
    localparam int NCOEF = 9;

    // Coefficients carried to the final products
    localparam int L_XX = 0;
    localparam int L_XY = 1;
    localparam int L_XZ = 2;
    localparam int L_XW = 3;
    localparam int L_YW = 4;
    localparam int L_ZW = 5;
    localparam int NLIN = 6;

    // Cofactors of the symmetric 3x3 block
    localparam int C_00 = 0;
    localparam int C_01 = 1;
    localparam int C_02 = 2;
    localparam int C_11 = 3;
    localparam int C_12 = 4;
    localparam int C_22 = 5;
    localparam int NCOF = 6;

    localparam int NPROD = 12;
    localparam int NTERM = 12;
    localparam int NDET  = 4;

    // Pair products feeding the cofactors (cofactor k = prod 2k - prod 2k+1)
    localparam int PROD_A [NPROD] = '{I_YY, I_YZ, I_XZ, I_XY, I_XY, I_YY,
                                      I_XX, I_XZ, I_XY, I_XX, I_XX, I_XY};
    localparam int PROD_B [NPROD] = '{I_ZZ, I_YZ, I_YZ, I_ZZ, I_YZ, I_XZ,
                                      I_ZZ, I_XZ, I_XZ, I_YZ, I_YY, I_XY};

    // Determinant terms: det d = sum of terms 3d..3d+2
    localparam int TERM_L [NTERM] = '{L_XX, L_XY, L_XZ, L_XW, L_YW, L_ZW,
                                      L_XW, L_YW, L_ZW, L_XW, L_YW, L_ZW};
    localparam int TERM_C [NTERM] = '{C_00, C_01, C_02, C_00, C_01, C_02,
                                      C_01, C_11, C_12, C_02, C_12, C_22};

    localparam logic [QB-1:0] Q_POS_LIM = {{(QB - 31){1'b0}}, {31{1'b1}}};
    localparam logic [QB-1:0] Q_NEG_LIM = {{(QB - 32){1'b0}}, 1'b1, {31{1'b0}}};
    localparam logic [31:0]   OUT_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [31:0]   OUT_NEG_SAT = 32'h8000_0000;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [PART_W-1:0] part_t;
    typedef logic signed [DW-1:0]     det_t;
    typedef logic [DW-1:0]            mag_t;
    typedef logic [NW-1:0]            rem_t;
    typedef logic [RW-1:0]            wide_t;
    typedef logic [QB-1:0]            quot_t;

    typedef struct packed {
        logic [31:0] quot;
        logic        sat;
    } div_res_t;

endpackage

@@ rtl/qov_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qov_div
// Pipelined restoring divider: (-num * 2^16) / den, truncated toward zero,
// saturated to signed 32 bits. One quotient bit per stage, DIV_LAT stages.
// ----------------------------------------------------------------------------
module qov_div import qov_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  det_t     num,
    input  det_t     den,
    output div_res_t res
);

    mag_t  na_reg;
    mag_t  da_reg;
    logic  nega_reg;
    wide_t n_wide;
    wide_t d_wide;
    rem_t  rem_reg [QB+1];
    mag_t  dd_reg  [QB+1];
    quot_t qq_reg  [QB+1];
    logic  neg_reg [QB+1];
    logic  ovf_reg [QB+1];
    logic  lim_hit;
    logic  sat_next;
    logic [31:0] quot_next;
    div_res_t res_reg;

    // Take magnitudes; the result is negative when the operand signs agree
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg   <= num[DW-1] ? mag_t'(-num) : mag_t'(num);
            da_reg   <= den[DW-1] ? mag_t'(-den) : mag_t'(den);
            nega_reg <= ~(num[DW-1] ^ den[DW-1]);
        end
    end

    // Scale the numerator and flag quotients of 2^33 or more
    assign n_wide = {{(QB - FRAC){1'b0}}, na_reg, {FRAC{1'b0}}};
    assign d_wide = {da_reg, {QB{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {na_reg, {FRAC{1'b0}}};
            dd_reg[0]  <= da_reg;
            qq_reg[0]  <= '0;
            neg_reg[0] <= nega_reg;
            ovf_reg[0] <= (n_wide >= d_wide);
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        wide_t r_w;
        wide_t d_sh;
        wide_t diff;
        logic  ge;
        quot_t q_set;

        assign r_w  = {{(RW - NW){1'b0}}, rem_reg[k-1]};
        assign d_sh = wide_t'(dd_reg[k-1]) << (QB - k);
        assign ge   = (r_w >= d_sh);
        assign diff = r_w - d_sh;

        always_comb
        begin
            q_set = qq_reg[k-1];
            q_set[QB-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[NW-1:0] : rem_reg[k-1];
                dd_reg[k]  <= dd_reg[k-1];
                qq_reg[k]  <= q_set;
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    // Clamp to the signed 32-bit range and apply the sign
    always_comb
    begin
        lim_hit   = neg_reg[QB] ? (qq_reg[QB] > Q_NEG_LIM) : (qq_reg[QB] > Q_POS_LIM);
        sat_next  = ovf_reg[QB] | lim_hit;
        if (sat_next)
            quot_next = neg_reg[QB] ? OUT_NEG_SAT : OUT_POS_SAT;
        else if (neg_reg[QB])
            quot_next = 32'd0 - qq_reg[QB][31:0];
        else
            quot_next = qq_reg[QB][31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.quot <= quot_next;
            res_reg.sat  <= sat_next;
        end
    end

    assign res = res_reg;

endmodule

@@ rtl/quadric_optimal_vertex.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadric_optimal_vertex
// Optimal vertex of a symmetric error quadric by Cramer's rule, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries the nine upper-triangle quadric
//   entries (signed Q16.16). Output channel out_valid/out_ready returns the
//   vertex coordinates (Q16.16), solvable and saturated, one per input.
//   The pipeline holds LAT = 43 register stages and advances while the
//   receiver takes results: 6 stages of exact determinant arithmetic
//   (capture, products, cofactors, split 32x65 products, recombine,
//   sums), 36 divider stages (operand magnitudes, numerator scaling, 33
//   stages that retire one quotient bit each, clamp), and one output
//   register. Throughput is one item per cycle while the receiver takes
//   results; the bit-serial divider pipeline sets the depth, not the rate.
//   When the receiver stalls with a result held, the whole pipeline freezes
//   and in_ready drops; in_ready stays high whenever the output register is
//   empty or being drained in the same cycle, so nothing is lost or repeated.
//   Reset clears all valid bits; the block accepts items right after reset.
//   A singular quadric gives zero coordinates with solvable and saturated low.
// ----------------------------------------------------------------------------
module quadric_optimal_vertex import qov_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [31:0] q_xx,
    input  logic signed [31:0] q_xy,
    input  logic signed [31:0] q_xz,
    input  logic signed [31:0] q_xw,
    input  logic signed [31:0] q_yy,
    input  logic signed [31:0] q_yz,
    input  logic signed [31:0] q_yw,
    input  logic signed [31:0] q_zz,
    input  logic signed [31:0] q_zw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z,
    output logic        solvable,
    output logic        saturated
);

    logic     en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    coef_t    q_in   [NCOEF];
    coef_t    q1_reg [NCOEF];
    prod_t    prod_reg [NPROD];
    coef_t    lin2_reg [NLIN];
    coef_t    lin3_reg [NLIN];
    cof_t     cof_reg  [NCOF];
    part_t    plo_reg  [NTERM];
    part_t    phi_reg  [NTERM];
    det_t     term_reg [NTERM];
    det_t     det_reg  [NDET];
    logic [DIV_LAT-1:0] zero_reg;
    div_res_t res_x;
    div_res_t res_y;
    div_res_t res_z;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic signed [31:0] vz_reg;
    logic     solv_reg;
    logic     sat_reg;

    // Advance the pipeline unless a held result is still waiting
    assign en        = ~vld_reg[LAT-1] | out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAT-1];

    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // Stage 1: capture coefficients
    assign q_in[I_XX] = q_xx;
    assign q_in[I_XY] = q_xy;
    assign q_in[I_XZ] = q_xz;
    assign q_in[I_XW] = q_xw;
    assign q_in[I_YY] = q_yy;
    assign q_in[I_YZ] = q_yz;
    assign q_in[I_YW] = q_yw;
    assign q_in[I_ZZ] = q_zz;
    assign q_in[I_ZW] = q_zw;

    always_ff @(posedge clk)
    begin
        if (en)
            q1_reg <= q_in;
    end

    // Stage 2: pair products for the cofactors; hold the linear terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NPROD; i++)
                prod_reg[i] <= q1_reg[PROD_A[i]] * q1_reg[PROD_B[i]];
            lin2_reg[L_XX] <= q1_reg[I_XX];
            lin2_reg[L_XY] <= q1_reg[I_XY];
            lin2_reg[L_XZ] <= q1_reg[I_XZ];
            lin2_reg[L_XW] <= q1_reg[I_XW];
            lin2_reg[L_YW] <= q1_reg[I_YW];
            lin2_reg[L_ZW] <= q1_reg[I_ZW];
        end
    end

    // Stage 3: cofactors of the 3x3 block
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NCOF; i++)
                cof_reg[i] <= cof_t'(prod_reg[2*i]) - cof_t'(prod_reg[2*i+1]);
            lin3_reg <= lin2_reg;
        end
    end

    // Stage 4: split each coefficient-by-cofactor product into two halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < NTERM; t++)
            begin
                plo_reg[t] <= lin3_reg[TERM_L[t]]
                              * $signed({1'b0, cof_reg[TERM_C[t]][COEF_W-1:0]});
                phi_reg[t] <= lin3_reg[TERM_L[t]]
                              * $signed(cof_reg[TERM_C[t]][COF_W-1:COEF_W]);
            end
        end
    end

    // Stage 5: recombine the halves
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < NTERM; t++)
                term_reg[t] <= ({{(DW - PART_W){phi_reg[t][PART_W-1]}}, phi_reg[t]} <<< COEF_W)
                               + {{(DW - PART_W){plo_reg[t][PART_W-1]}}, plo_reg[t]};
        end
    end

    // Stage 6: main and column-replaced determinants
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int d = 0; d < NDET; d++)
                det_reg[d] <= term_reg[3*d] + term_reg[3*d+1] + term_reg[3*d+2];
        end
    end

    // Carry the singular flag alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
            zero_reg <= {zero_reg[DIV_LAT-2:0], (det_reg[0] == '0)};
    end

    qov_div u_div_x (.clk(clk), .en(en), .num(det_reg[1]), .den(det_reg[0]), .res(res_x));
    qov_div u_div_y (.clk(clk), .en(en), .num(det_reg[2]), .den(det_reg[0]), .res(res_y));
    qov_div u_div_z (.clk(clk), .en(en), .num(det_reg[3]), .den(det_reg[0]), .res(res_z));

    // Output register: drop the quotients of a singular quadric
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[DIV_LAT-1])
            begin
                vx_reg   <= '0;
                vy_reg   <= '0;
                vz_reg   <= '0;
                solv_reg <= 1'b0;
                sat_reg  <= 1'b0;
            end
            else
            begin
                vx_reg   <= res_x.quot;
                vy_reg   <= res_y.quot;
                vz_reg   <= res_z.quot;
                solv_reg <= 1'b1;
                sat_reg  <= res_x.sat | res_y.sat | res_z.sat;
            end
        end
    end

    assign vertex_x  = vx_reg;
    assign vertex_y  = vy_reg;
    assign vertex_z  = vz_reg;
    assign solvable  = solv_reg;
    assign saturated = sat_reg;

    // A singular result carries no coordinates and no clamp
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !solvable) |-> (vertex_x == 0 && vertex_y == 0 && vertex_z == 0
                                      && !saturated))
        else $error("singular result with nonzero payload");

    // A clamp implies a solvable quadric and a coordinate at a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (solvable &&
            (vertex_x == $signed(OUT_POS_SAT) || vertex_x == $signed(OUT_NEG_SAT) ||
             vertex_y == $signed(OUT_POS_SAT) || vertex_y == $signed(OUT_NEG_SAT) ||
             vertex_z == $signed(OUT_POS_SAT) || vertex_z == $signed(OUT_NEG_SAT))))
        else $error("saturated without a clamped coordinate");

    // A stalled output freezes the pipeline, so the input side must hold off
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while output stalled");

endmodule
